// ===== rtl/core/lprl_pkg.sv =====
// ----------------------------------------------------------------------------
// lprl_pkg
// Shared types and codes for the longest-prefix route lookup block.
// ----------------------------------------------------------------------------
package lprl_pkg;

  localparam int ADDR_BITS = 32;
  localparam int LEN_W     = 6;
  localparam int IFACE_W   = 4;
  localparam int TTL_W     = 8;
  localparam int STATUS_W  = 3;
  localparam int KIND_W    = 2;
  localparam int QUEUE_DEPTH = 2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FORWARDED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_ROUTE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  // command kinds produced by the front end
  localparam logic [KIND_W-1:0] CMD_ADD     = 2'd0;
  localparam logic [KIND_W-1:0] CMD_REJECT  = 2'd1;
  localparam logic [KIND_W-1:0] CMD_EXPIRED = 2'd2;
  localparam logic [KIND_W-1:0] CMD_LOOKUP  = 2'd3;

  // one stored route
  typedef struct packed {
    logic [ADDR_BITS-1:0] prefix;
    logic [LEN_W-1:0]     len;
    logic                 gw;
    logic [ADDR_BITS-1:0] hop;
    logic [IFACE_W-1:0]   iface;
  } route_t;

  // classified command passed from front to back
  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    route_t               route;
    logic [ADDR_BITS-1:0] dst;
    logic [TTL_W-1:0]     ttl;   // already decremented
  } cmd_t;

  // network mask for a saturated prefix length
  function automatic logic [ADDR_BITS-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_BITS-1:0] m;
    if (len == '0) begin
      m = '0;
    end else if (len >= LEN_W'(ADDR_BITS)) begin
      m = '1;
    end else begin
      m = {ADDR_BITS{1'b1}} << (LEN_W'(ADDR_BITS) - len);
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/lprl_if.sv =====
// ----------------------------------------------------------------------------
// lprl_if
// Valid/ready channel interfaces for requests and results.
// ----------------------------------------------------------------------------
interface lprl_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] rt_prefix;
  logic [5:0]  prefix_len;
  logic        has_next_hop;
  logic [31:0] next_hop_addr;
  logic [3:0]  route_iface;
  logic [31:0] dst_addr;
  logic [7:0]  ttl_in;

  modport source (
    output valid, func, rt_prefix, prefix_len, has_next_hop,
           next_hop_addr, route_iface, dst_addr, ttl_in,
    input  ready
  );
  modport sink (
    input  valid, func, rt_prefix, prefix_len, has_next_hop,
           next_hop_addr, route_iface, dst_addr, ttl_in,
    output ready
  );
endinterface

interface lprl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  out_iface;
  logic [31:0] hop_addr;
  logic [7:0]  ttl_out;

  modport source (
    output valid, status, out_iface, hop_addr, ttl_out,
    input  ready
  );
  modport sink (
    input  valid, status, out_iface, hop_addr, ttl_out,
    output ready
  );
endinterface

// ===== rtl/core/longest_prefix_route_lookup.sv =====
// Add, expired, refused and empty-table requests are answered from the result
// register; a lookup on a populated table reads one table entry per cycle from
// the route memory, compares the registered read data and then loads the result.
// A lookup holds off the next request until its table walk ends; other requests
// are taken every cycle while the result register is free.
// Reset (synchronous, active low) empties the table and all queues.
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup
// IPv4 forwarding table with append-only routes and longest-prefix lookup.
// ----------------------------------------------------------------------------
module longest_prefix_route_lookup #(
  parameter int TABLE_DEPTH = 32,
  parameter int IFACE_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  lprl_in_if.sink     in_ch,
  lprl_out_if.source  out_ch
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic             f_valid, f_ready;
  lprl_pkg::cmd_t   f_cmd;
  logic             q_valid, q_ready;
  lprl_pkg::cmd_t   q_cmd;
  logic [CNT_W-1:0] entry_count;

  lprl_front #(
    .IFACE_COUNT (IFACE_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  lprl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  lprl_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (q_valid),
    .cmd_ready   (q_ready),
    .cmd         (q_cmd),
    .out_ch      (out_ch),
    .entry_count (entry_count)
  );

  // table never grows past its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count <= CNT_W'(TABLE_DEPTH))
    else $error("route count exceeds table depth");

  // every table append is answered with a route-added result
  a_count_added: assert property (@(posedge clk) disable iff (!rst_n)
    (entry_count != $past(entry_count)) |->
      (out_ch.valid && out_ch.status == lprl_pkg::ST_ADDED))
    else $error("table grew without an added result");

  // forwarded datagrams always leave with a live ttl
  a_fwd_ttl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == lprl_pkg::ST_FORWARDED) |-> (out_ch.ttl_out != 8'd0))
    else $error("forwarded datagram with zero ttl");

  // non-forward results carry a zero payload
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != lprl_pkg::ST_FORWARDED) |->
      (out_ch.out_iface == 4'd0 && out_ch.hop_addr == 32'd0 && out_ch.ttl_out == 8'd0))
    else $error("non-forward result with nonzero payload");

endmodule

// ===== rtl/core/lprl_front.sv =====
// ----------------------------------------------------------------------------
// lprl_front
// Accepts request transactions, classifies them and registers the command.
// ----------------------------------------------------------------------------
module lprl_front #(
  parameter int IFACE_COUNT = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  lprl_in_if.sink           in_ch,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output lprl_pkg::cmd_t    cmd
);

  logic           vld_r, vld_nxt;
  lprl_pkg::cmd_t cmd_r, cmd_nxt;
  logic           take;

  assign in_ch.ready = !vld_r || cmd_ready;
  assign take        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = vld_r;
  assign cmd         = cmd_r;

  // classify the incoming transaction
  always_comb begin
    cmd_nxt              = cmd_r;
    cmd_nxt.route.prefix = in_ch.rt_prefix;
    cmd_nxt.route.len    = (in_ch.prefix_len > lprl_pkg::LEN_W'(lprl_pkg::ADDR_BITS)) ?
                           lprl_pkg::LEN_W'(lprl_pkg::ADDR_BITS) : in_ch.prefix_len;
    cmd_nxt.route.gw     = in_ch.has_next_hop;
    cmd_nxt.route.hop    = in_ch.next_hop_addr;
    cmd_nxt.route.iface  = in_ch.route_iface;
    cmd_nxt.dst          = in_ch.dst_addr;
    cmd_nxt.ttl          = in_ch.ttl_in - 8'd1;
    priority if (!in_ch.func) begin
      cmd_nxt.kind = (32'(in_ch.route_iface) >= 32'(IFACE_COUNT)) ?
                     lprl_pkg::CMD_REJECT : lprl_pkg::CMD_ADD;
    end else if (in_ch.ttl_in <= 8'd1) begin
      cmd_nxt.kind = lprl_pkg::CMD_EXPIRED;
    end else begin
      cmd_nxt.kind = lprl_pkg::CMD_LOOKUP;
    end
  end

  // holding stage valid
  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (cmd_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// ===== rtl/core/lprl_queue.sv =====
// ----------------------------------------------------------------------------
// lprl_queue
// Short command queue decoupling the front end from the table walker.
// ----------------------------------------------------------------------------
module lprl_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  lprl_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output lprl_pkg::cmd_t pop_data
);

  localparam int PTR_W = $clog2(lprl_pkg::QUEUE_DEPTH);
  localparam int LVL_W = $clog2(lprl_pkg::QUEUE_DEPTH + 1);

  lprl_pkg::cmd_t   slot_r [lprl_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic             do_push, do_pop;

  assign push_ready = (level_r != LVL_W'(lprl_pkg::QUEUE_DEPTH));
  assign pop_valid  = (level_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(lprl_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(lprl_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      level_nxt = level_r + 1'b1;
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/lprl_back.sv =====
// ----------------------------------------------------------------------------
// lprl_back
// Route table memory, sequential prefix walk and result register.
// ----------------------------------------------------------------------------
module lprl_back #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cmd_valid,
  output logic                                 cmd_ready,
  input  lprl_pkg::cmd_t                       cmd,
  lprl_out_if.source                           out_ch,
  output logic [$clog2(TABLE_DEPTH + 1)-1:0]   entry_count
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  lprl_pkg::route_t mem [TABLE_DEPTH];

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  lprl_pkg::route_t rd_data_r;
  logic             rd_vld_r;
  logic             found_r, found_nxt;
  logic [5:0]       best_len_r, best_len_nxt;
  logic             best_gw_r, best_gw_nxt;
  logic [31:0]      best_hop_r, best_hop_nxt;
  logic [3:0]       best_iface_r, best_iface_nxt;
  logic [31:0]      dst_r;
  logic [7:0]       ttl_r;
  logic             start_scan;

  logic             out_vld_r, out_vld_nxt;
  logic [2:0]       out_status_r, out_status_nxt;
  logic [3:0]       out_iface_r, out_iface_nxt;
  logic [31:0]      out_hop_r, out_hop_nxt;
  logic [7:0]       out_ttl_r, out_ttl_nxt;
  logic             out_load;

  logic             slot_free, direct, do_pop, hit, take_best, scan_last;
  logic             wr_en;

  assign entry_count = count_r;
  assign slot_free   = !out_vld_r || out_ch.ready;
  assign direct      = (cmd.kind != lprl_pkg::CMD_LOOKUP) || (count_r == '0);
  assign cmd_ready   = (state_r == S_IDLE) && (!direct || slot_free);
  assign do_pop      = cmd_valid && cmd_ready;
  assign scan_last   = (CNT_W'(scan_idx_r) == count_r - CNT_W'(1));

  assign out_ch.valid     = out_vld_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.out_iface = out_iface_r;
  assign out_ch.hop_addr  = out_hop_r;
  assign out_ch.ttl_out   = out_ttl_r;

  // compare the entry read last cycle against the destination
  assign hit = ((rd_data_r.prefix ^ dst_r) & lprl_pkg::len_mask(rd_data_r.len)) == '0;
  assign take_best = rd_vld_r && hit && (!found_r || (rd_data_r.len > best_len_r));

  always_comb begin
    found_nxt      = found_r;
    best_len_nxt   = best_len_r;
    best_gw_nxt    = best_gw_r;
    best_hop_nxt   = best_hop_r;
    best_iface_nxt = best_iface_r;
    if (start_scan) begin
      found_nxt = 1'b0;
    end else if (take_best) begin
      found_nxt      = 1'b1;
      best_len_nxt   = rd_data_r.len;
      best_gw_nxt    = rd_data_r.gw;
      best_hop_nxt   = rd_data_r.hop;
      best_iface_nxt = rd_data_r.iface;
    end
  end

  // sequencer: direct answers, table writes and the scan
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    start_scan     = 1'b0;
    wr_en          = 1'b0;
    out_load       = 1'b0;
    out_status_nxt = out_status_r;
    out_iface_nxt  = '0;
    out_hop_nxt    = '0;
    out_ttl_nxt    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (do_pop) begin
          unique case (cmd.kind)
            lprl_pkg::CMD_ADD: begin
              out_load = 1'b1;
              if (count_r == CNT_W'(TABLE_DEPTH)) begin
                out_status_nxt = lprl_pkg::ST_FULL;
              end else begin
                wr_en          = 1'b1;
                count_nxt      = count_r + 1'b1;
                out_status_nxt = lprl_pkg::ST_ADDED;
              end
            end
            lprl_pkg::CMD_REJECT: begin
              out_load       = 1'b1;
              out_status_nxt = lprl_pkg::ST_FULL;
            end
            lprl_pkg::CMD_EXPIRED: begin
              out_load       = 1'b1;
              out_status_nxt = lprl_pkg::ST_EXPIRED;
            end
            lprl_pkg::CMD_LOOKUP: begin
              if (count_r == '0) begin
                out_load       = 1'b1;
                out_status_nxt = lprl_pkg::ST_NO_ROUTE;
              end else begin
                start_scan   = 1'b1;
                scan_idx_nxt = '0;
                state_nxt    = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          if (found_r) begin
            out_status_nxt = lprl_pkg::ST_FORWARDED;
            out_iface_nxt  = best_iface_r;
            out_hop_nxt    = best_gw_r ? best_hop_r : dst_r;
            out_ttl_nxt    = ttl_r;
          end else begin
            out_status_nxt = lprl_pkg::ST_NO_ROUTE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register valid
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      rd_vld_r  <= 1'b0;
      found_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      rd_vld_r  <= (state_r == S_SCAN);
      found_r   <= found_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    scan_idx_r   <= scan_idx_nxt;
    best_len_r   <= best_len_nxt;
    best_gw_r    <= best_gw_nxt;
    best_hop_r   <= best_hop_nxt;
    best_iface_r <= best_iface_nxt;
    if (start_scan) begin
      dst_r <= cmd.dst;
      ttl_r <= cmd.ttl;
    end
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_iface_r  <= out_iface_nxt;
      out_hop_r    <= out_hop_nxt;
      out_ttl_r    <= out_ttl_nxt;
    end
  end

  // route table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= cmd.route;
    end
    rd_data_r <= mem[scan_idx_r];
  end

endmodule

// ===== sim/lprl_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lprl_tb_pkg
// Request and verdict types shared by the route lookup testbench and checker.
// ----------------------------------------------------------------------------
package lprl_tb_pkg;

  // request kind carried in the func field
  typedef enum logic {
    FN_ADD_ROUTE = 1'b0,
    FN_FORWARD   = 1'b1
  } func_t;

  // one request transaction, all fields as the channel carries them
  typedef struct packed {
    func_t                          func;
    logic [lprl_pkg::ADDR_BITS-1:0] rt_prefix;
    logic [lprl_pkg::LEN_W-1:0]     prefix_len;
    logic                           has_next_hop;
    logic [lprl_pkg::ADDR_BITS-1:0] next_hop_addr;
    logic [lprl_pkg::IFACE_W-1:0]   route_iface;
    logic [lprl_pkg::ADDR_BITS-1:0] dst_addr;
    logic [lprl_pkg::TTL_W-1:0]     ttl_in;
  } route_req_t;

  // one verdict transaction
  typedef struct packed {
    logic [lprl_pkg::STATUS_W-1:0]  status;
    logic [lprl_pkg::IFACE_W-1:0]   iface;
    logic [lprl_pkg::ADDR_BITS-1:0] hop;
    logic [lprl_pkg::TTL_W-1:0]     ttl;
  } route_verdict_t;

endpackage

// ===== sim/lprl_route_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lprl_route_checker
// Watches both channels of the route lookup block, keeps its own copy of the
// forwarding table, predicts the verdict of every accepted request and
// compares each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module lprl_route_checker #(
  parameter int TABLE_DEPTH = 32,
  parameter int IFACE_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  lprl_in_if          in_mon,
  lprl_out_if         out_mon,
  output int unsigned fail_count,
  output int unsigned pending_count
);

  // shadow forwarding table
  logic [lprl_pkg::ADDR_BITS-1:0] tbl_prefix [TABLE_DEPTH];
  int unsigned                    tbl_len    [TABLE_DEPTH];
  logic                           tbl_gw     [TABLE_DEPTH];
  logic [lprl_pkg::ADDR_BITS-1:0] tbl_hop    [TABLE_DEPTH];
  logic [lprl_pkg::IFACE_W-1:0]   tbl_iface  [TABLE_DEPTH];
  int unsigned                    tbl_count;

  lprl_tb_pkg::route_verdict_t pending_verdicts [$];

  // applies one request to the shadow table and returns its verdict
  function automatic lprl_tb_pkg::route_verdict_t route_verdict(
      input lprl_tb_pkg::route_req_t req);
    lprl_tb_pkg::route_verdict_t    v;
    int unsigned                    len;
    int unsigned                    best_len;
    int                             best;
    int                             i;
    logic [lprl_pkg::ADDR_BITS-1:0] net_mask;
    v = '0;
    if (req.func == lprl_tb_pkg::FN_ADD_ROUTE) begin
      if (tbl_count >= TABLE_DEPTH || req.route_iface >= IFACE_COUNT) begin
        v.status = lprl_pkg::ST_FULL;
      end else begin
        // lengths past the address width act as host routes
        len = (req.prefix_len > lprl_pkg::ADDR_BITS) ? lprl_pkg::ADDR_BITS : req.prefix_len;
        tbl_prefix[tbl_count] = req.rt_prefix;
        tbl_len[tbl_count]    = len;
        tbl_gw[tbl_count]     = req.has_next_hop;
        tbl_hop[tbl_count]    = req.next_hop_addr;
        tbl_iface[tbl_count]  = req.route_iface;
        tbl_count++;
        v.status = lprl_pkg::ST_ADDED;
      end
    end else if (req.ttl_in <= 1) begin
      v.status = lprl_pkg::ST_EXPIRED;
    end else begin
      // longest match wins; strict compare keeps the earliest on a tie
      best     = -1;
      best_len = 0;
      for (i = 0; i < tbl_count; i++) begin
        net_mask = ~({lprl_pkg::ADDR_BITS{1'b1}} >> tbl_len[i]);
        if (((tbl_prefix[i] ^ req.dst_addr) & net_mask) == '0 &&
            (best < 0 || tbl_len[i] > best_len)) begin
          best     = i;
          best_len = tbl_len[i];
        end
      end
      if (best < 0) begin
        v.status = lprl_pkg::ST_NO_ROUTE;
      end else begin
        v.status = lprl_pkg::ST_FORWARDED;
        v.iface  = tbl_iface[best];
        v.hop    = tbl_gw[best] ? tbl_hop[best] : req.dst_addr;
        v.ttl    = req.ttl_in - 1'b1;
      end
    end
    return v;
  endfunction

  // result side is checked before the request side: a request accepted in
  // this cycle can never be answered in the same cycle
  always @(posedge clk) begin : monitor
    lprl_tb_pkg::route_req_t     req;
    lprl_tb_pkg::route_verdict_t want;
    lprl_tb_pkg::route_verdict_t got;
    if (!rst_n) begin
      tbl_count  = 0;
      fail_count = 0;
      pending_verdicts.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.status, out_mon.out_iface, out_mon.hop_addr, out_mon.ttl_out};
        if (pending_verdicts.size() == 0) begin
          $error("result transaction with no request outstanding");
          fail_count++;
        end else begin
          want = pending_verdicts.pop_front();
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            fail_count++;
          end
          if (got.iface !== want.iface) begin
            $error("out_iface mismatch: expected %0d, actual %0d", want.iface, got.iface);
            fail_count++;
          end
          if (got.hop !== want.hop) begin
            $error("hop_addr mismatch: expected %08h, actual %08h", want.hop, got.hop);
            fail_count++;
          end
          if (got.ttl !== want.ttl) begin
            $error("ttl_out mismatch: expected %0d, actual %0d", want.ttl, got.ttl);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        req.func          = lprl_tb_pkg::func_t'(in_mon.func);
        req.rt_prefix     = in_mon.rt_prefix;
        req.prefix_len    = in_mon.prefix_len;
        req.has_next_hop  = in_mon.has_next_hop;
        req.next_hop_addr = in_mon.next_hop_addr;
        req.route_iface   = in_mon.route_iface;
        req.dst_addr      = in_mon.dst_addr;
        req.ttl_in        = in_mon.ttl_in;
        pending_verdicts.insert(pending_verdicts.size(), route_verdict(req));
      end
    end
    pending_count = pending_verdicts.size();
  end

endmodule

// ===== sim/longest_prefix_route_lookup_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup_tb
// Drives route adds and datagram lookups into the route lookup block: a
// directed set covering expiry, no-route, ties, saturated lengths and the
// default route, then random traffic aimed near stored prefixes until the
// table fills and adds get refused. Both channels idle at random, and the
// result side holds off once for a long stretch. The checker judges results.
// ----------------------------------------------------------------------------
module longest_prefix_route_lookup_tb;

  localparam int TABLE_DEPTH     = 32;
  localparam int IFACE_COUNT     = 16;
  localparam int RANDOM_REQUESTS = 600;
  localparam int MAX_GAP         = 13;
  localparam int HOLD_OFF_AT     = 60;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 40;
  localparam int QUIET_LIMIT     = 3000;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending_count;

  // prefixes the block has room for, in table order
  logic [lprl_pkg::ADDR_BITS-1:0] known_prefix [$];
  int unsigned                    send_burst;

  lprl_in_if  in_ch ();
  lprl_out_if out_ch ();

  longest_prefix_route_lookup #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IFACE_COUNT (IFACE_COUNT)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lprl_route_checker #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IFACE_COUNT (IFACE_COUNT)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // every field random; callers override the ones that matter
  function automatic lprl_tb_pkg::route_req_t noise_request();
    lprl_tb_pkg::route_req_t r;
    r.func          = lprl_tb_pkg::FN_FORWARD;
    r.rt_prefix     = $urandom;
    r.prefix_len    = 6'($urandom_range(0, 63));
    r.has_next_hop  = 1'($urandom_range(0, 1));
    r.next_hop_addr = $urandom;
    r.route_iface   = 4'($urandom_range(0, 15));
    r.dst_addr      = $urandom;
    r.ttl_in        = 8'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic lprl_tb_pkg::route_req_t make_add(
      input logic [lprl_pkg::ADDR_BITS-1:0] prefix,
      input logic [lprl_pkg::LEN_W-1:0] len, input logic gw,
      input logic [lprl_pkg::ADDR_BITS-1:0] hop,
      input logic [lprl_pkg::IFACE_W-1:0] iface);
    lprl_tb_pkg::route_req_t r;
    r               = noise_request();
    r.func          = lprl_tb_pkg::FN_ADD_ROUTE;
    r.rt_prefix     = prefix;
    r.prefix_len    = len;
    r.has_next_hop  = gw;
    r.next_hop_addr = hop;
    r.route_iface   = iface;
    return r;
  endfunction

  function automatic lprl_tb_pkg::route_req_t make_route(
      input logic [lprl_pkg::ADDR_BITS-1:0] dst,
      input logic [lprl_pkg::TTL_W-1:0] ttl);
    lprl_tb_pkg::route_req_t r;
    r          = noise_request();
    r.dst_addr = dst;
    r.ttl_in   = ttl;
    return r;
  endfunction

  // a stored prefix with a random number of low bits scrambled
  function automatic logic [lprl_pkg::ADDR_BITS-1:0] near_prefix();
    int unsigned k;
    if (known_prefix.size() == 0) begin
      return $urandom;
    end
    k = $urandom_range(0, 32);
    return known_prefix[$urandom_range(0, known_prefix.size() - 1)] ^
           (32'($urandom) & 32'((64'd1 << k) - 1));
  endfunction

  // offer one transaction after a random gap; returns at the next falling edge
  task automatic offer_request(input lprl_tb_pkg::route_req_t r);
    int unsigned gap;
    if (send_burst > 0) begin
      send_burst--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 24) == 0) send_burst = $urandom_range(10, 40);
    end
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.func          <= r.func;
    in_ch.rt_prefix     <= r.rt_prefix;
    in_ch.prefix_len    <= r.prefix_len;
    in_ch.has_next_hop  <= r.has_next_hop;
    in_ch.next_hop_addr <= r.next_hop_addr;
    in_ch.route_iface   <= r.route_iface;
    in_ch.dst_addr      <= r.dst_addr;
    in_ch.ttl_in        <= r.ttl_in;
    if (r.func == lprl_tb_pkg::FN_ADD_ROUTE && known_prefix.size() < TABLE_DEPTH) begin
      known_prefix.insert(known_prefix.size(), r.rt_prefix);
    end
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // request side: reset, directed set, random traffic, drain, verdict
  initial begin : stimulus
    lprl_tb_pkg::route_req_t r;
    int unsigned             n;
    rst_n               = 1'b0;
    send_burst          = 0;
    in_ch.valid         = 1'b0;
    in_ch.func          = lprl_tb_pkg::FN_ADD_ROUTE;
    in_ch.rt_prefix     = '0;
    in_ch.prefix_len    = '0;
    in_ch.has_next_hop  = 1'b0;
    in_ch.next_hop_addr = '0;
    in_ch.route_iface   = '0;
    in_ch.dst_addr      = '0;
    in_ch.ttl_in        = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // expiry and lookups on an empty table
    offer_request(make_route(32'h0000_0000, 8'd0));
    offer_request(make_route(32'hFFFF_FFFF, 8'd1));
    offer_request(make_route(32'h0A01_0203, 8'd255));
    // nested prefixes, host routes, a saturated length and an equal-length tie
    offer_request(make_add(32'h0A00_0000, 6'd8,  1'b1, 32'hC0A8_0001, 4'd1));
    offer_request(make_add(32'h0A01_0000, 6'd16, 1'b0, 32'hDEAD_BEEF, 4'd2));
    offer_request(make_add(32'hFFFF_FFFF, 6'd32, 1'b1, 32'hFFFF_FFFF, 4'd15));
    offer_request(make_add(32'h0000_0000, 6'd63, 1'b1, 32'h0000_0000, 4'd0));
    offer_request(make_add(32'hC0A8_0000, 6'd16, 1'b1, 32'h0102_0304, 4'd3));
    offer_request(make_add(32'hC0A8_0000, 6'd16, 1'b1, 32'h0506_0708, 4'd4));
    offer_request(make_add(32'h0A01_0203, 6'd33, 1'b0, 32'h1111_1111, 4'd5));
    offer_request(make_route(32'h0A01_0203, 8'd2));
    offer_request(make_route(32'h0A01_0999, 8'd64));
    offer_request(make_route(32'h0A7F_0000, 8'd255));
    offer_request(make_route(32'hC0A8_1234, 8'd3));
    offer_request(make_route(32'hFFFF_FFFF, 8'd128));
    offer_request(make_route(32'h0000_0000, 8'd10));
    offer_request(make_route(32'h0B00_0000, 8'd10));
    offer_request(make_route(32'h0000_0001, 8'd200));
    // default route catches everything else
    offer_request(make_add(32'h1234_5678, 6'd0, 1'b1, 32'h0A0A_0A0A, 4'd7));
    offer_request(make_route(32'h0B00_0000, 8'd10));
    offer_request(make_route(32'hFFFF_FFFE, 8'd2));
    offer_request(make_route(32'h0A01_0203, 8'd0));

    // random traffic: adds until the table fills, then refused adds mixed in
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if ($urandom_range(0, 99) < ((known_prefix.size() < TABLE_DEPTH) ? 12 : 6)) begin
        r = make_add(($urandom_range(0, 1) != 0) ? near_prefix() : 32'($urandom),
                     ($urandom_range(0, 19) == 0) ? 6'd0 :
                     ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63)) :
                                                    6'($urandom_range(1, 32)),
                     1'($urandom_range(0, 1)), $urandom, 4'($urandom_range(0, 15)));
      end else begin
        r = make_route(($urandom_range(0, 3) != 0) ? near_prefix() : 32'($urandom),
                       ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 1)) :
                                                     8'($urandom_range(2, 255)));
      end
      offer_request(r);
    end
    in_ch.valid <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result side: random stalls, bursts without stalls, one long hold-off
  initial begin : receiver
    int unsigned stall;
    int unsigned burst;
    int unsigned taken;
    out_ch.ready = 1'b0;
    burst        = 0;
    taken        = 0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (taken == HOLD_OFF_AT) begin
        stall = HOLD_OFF_CYCLES;
      end else if (burst > 0) begin
        burst--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 24) == 0) burst = $urandom_range(10, 40);
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
      @(negedge clk);
    end
  end

  // ends the run when no transaction moves on either channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

endmodule
